// ===== hw/rtl/mcpid_pkg.sv =====
// Shared types, constants and register codes for the multi-channel PID controller.
// Used by multi_channel_pid_controller_unit; depends on nothing else.
`timescale 1ns / 1ps

package mcpid_pkg;

    localparam int CHANNELS           = 4;
    localparam int SAMPLE_BITS        = 16;
    localparam int GAIN_FRACTION_BITS = 12;

    localparam int CHAN_W   = 2;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 16;
    localparam int INTEG_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Derived datapath widths
    localparam int ERR_W   = SAMPLE_BITS + 1;
    localparam int DIFF_W  = SAMPLE_BITS + 2;
    localparam int SUM_W   = INTEG_W + 2;
    localparam int P_W     = GAIN_W + 1 + ERR_W;
    localparam int I_W     = GAIN_W + 1 + INTEG_W;
    localparam int D_W     = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W   = I_W + 2;
    localparam int Y_W     = ACC_W - GAIN_FRACTION_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_OUT_MAX      = 3'd3,
        REG_OUT_MIN      = 3'd4,
        REG_INTEGRAL_MAX = 3'd5,
        REG_INTEGRAL_MIN = 3'd6
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]         GAIN_P_RESET       = 16'd8192;
    localparam logic [GAIN_W-1:0]         GAIN_I_RESET       = 16'd410;
    localparam logic [GAIN_W-1:0]         GAIN_D_RESET       = 16'd205;
    localparam logic signed [LIMIT_W-1:0] OUT_MAX_RESET      = 16'sd100;
    localparam logic signed [LIMIT_W-1:0] OUT_MIN_RESET      = -16'sd100;
    localparam logic signed [INTEG_W-1:0] INTEGRAL_MAX_RESET = 32'sd1000;
    localparam logic signed [INTEG_W-1:0] INTEGRAL_MIN_RESET = -32'sd1000;

    typedef struct packed {
        logic [CHAN_W-1:0]             channel;
        logic signed [SAMPLE_BITS-1:0] setpoint;
        logic signed [SAMPLE_BITS-1:0] measured;
    } pid_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0]         channel_out;
        logic signed [LIMIT_W-1:0] drive;
        logic                      saturated;
    } pid_out_t;

endpackage

// ===== hw/rtl/multi_channel_pid_controller_unit.sv =====
// Top level of the four-channel positional PID controller with integral clamp.
// Depends on mcpid_pkg for widths, payload structs and register codes.
`timescale 1ns / 1ps

// Usage
//   in channel  : in_valid/in_ready, word = {channel, setpoint, measured}.
//   out channel : out_valid/out_ready, word = {channel_out, drive, saturated},
//                 one result word per input word, in input order.
//   cfg channel : cfg_valid/cfg_ready with cfg_index and cfg_data; always ready.
//                 Write only while the block is idle.
// Pipeline: input register -> error/integral/derivative stage (channel state
//   is updated here) -> product, sum, shift and saturate into the output
//   register. One word per cycle is sustained while out_ready stays high; a
//   word for the same channel may follow in the next cycle because the
//   state update lands in a single read-modify-write stage.
// Stall: each stage moves when the stage after it is empty or moving, so
//   bubbles are squeezed out; in_ready drops only when all three stages hold
//   words and out_ready is low. Nothing is lost or repeated under stall.
// Reset (rst_n low, asynchronous): pipeline empty, per-channel integral and
//   previous error cleared, configuration back to its default values.
module multi_channel_pid_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mcpid_pkg::pid_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mcpid_pkg::pid_out_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcpid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcpid_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers
    logic [mcpid_pkg::GAIN_W-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [mcpid_pkg::LIMIT_W-1:0] out_max_reg, out_min_reg;
    logic signed [mcpid_pkg::INTEG_W-1:0] integral_max_reg, integral_min_reg;

    // Per-channel loop state
    logic signed [mcpid_pkg::INTEG_W-1:0] error_sum_reg [mcpid_pkg::CHANNELS];
    logic signed [mcpid_pkg::ERR_W-1:0]   prev_err_reg  [mcpid_pkg::CHANNELS];

    // Stage 0: input register
    logic               in_valid_reg;
    mcpid_pkg::pid_in_t in_word_reg;

    // Stage 1: error terms
    logic                                  mid_valid_reg;
    logic                                  mid_live_reg;
    logic [mcpid_pkg::CHAN_W-1:0]          mid_chan_reg;
    logic signed [mcpid_pkg::ERR_W-1:0]    mid_err_reg, mid_err_next;
    logic signed [mcpid_pkg::INTEG_W-1:0]  mid_integ_reg, mid_integ_next;
    logic signed [mcpid_pkg::DIFF_W-1:0]   mid_deriv_reg, mid_deriv_next;

    // Stage 2: output register
    logic                out_valid_reg;
    mcpid_pkg::pid_out_t out_word_reg, out_word_next;

    logic en0, en1, en2;
    logic live0, upd;

    assign en2 = !out_valid_reg || out_ready;
    assign en1 = !mid_valid_reg || en2;
    assign en0 = !in_valid_reg || en1;

    assign in_ready  = en0;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;
    assign cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg       <= mcpid_pkg::GAIN_P_RESET;
            gain_i_reg       <= mcpid_pkg::GAIN_I_RESET;
            gain_d_reg       <= mcpid_pkg::GAIN_D_RESET;
            out_max_reg      <= mcpid_pkg::OUT_MAX_RESET;
            out_min_reg      <= mcpid_pkg::OUT_MIN_RESET;
            integral_max_reg <= mcpid_pkg::INTEGRAL_MAX_RESET;
            integral_min_reg <= mcpid_pkg::INTEGRAL_MIN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mcpid_pkg::REG_GAIN_P:       gain_p_reg  <= cfg_data[mcpid_pkg::GAIN_W-1:0];
                mcpid_pkg::REG_GAIN_I:       gain_i_reg  <= cfg_data[mcpid_pkg::GAIN_W-1:0];
                mcpid_pkg::REG_GAIN_D:       gain_d_reg  <= cfg_data[mcpid_pkg::GAIN_W-1:0];
                mcpid_pkg::REG_OUT_MAX:      out_max_reg <= cfg_data[mcpid_pkg::LIMIT_W-1:0];
                mcpid_pkg::REG_OUT_MIN:      out_min_reg <= cfg_data[mcpid_pkg::LIMIT_W-1:0];
                mcpid_pkg::REG_INTEGRAL_MAX: integral_max_reg <= cfg_data[mcpid_pkg::INTEG_W-1:0];
                mcpid_pkg::REG_INTEGRAL_MIN: integral_min_reg <= cfg_data[mcpid_pkg::INTEG_W-1:0];
                default: ;  // unmapped index: write ignored
            endcase
        end
    end

    // ---------------- stage 0 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (en0)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
            in_word_reg <= in_data;
    end

    // ---------------- stage 1: error, clamped integral, derivative ----------------
    logic signed [mcpid_pkg::SUM_W-1:0] integ_sum;
    logic signed [mcpid_pkg::SUM_W-1:0] imax_ext, imin_ext;

    assign live0 = (mcpid_pkg::CHAN_W + 1)'(in_word_reg.channel)
                   < (mcpid_pkg::CHAN_W + 1)'(mcpid_pkg::CHANNELS);
    assign upd   = in_valid_reg && en1 && live0;

    always_comb
    begin
        mid_err_next = mcpid_pkg::ERR_W'(in_word_reg.setpoint)
                     - mcpid_pkg::ERR_W'(in_word_reg.measured);
        integ_sum = mcpid_pkg::SUM_W'(error_sum_reg[in_word_reg.channel])
                  + mcpid_pkg::SUM_W'(mid_err_next);
        imax_ext  = mcpid_pkg::SUM_W'(integral_max_reg);
        imin_ext  = mcpid_pkg::SUM_W'(integral_min_reg);
        // upper bound is tested first, so it wins where a sum lies beyond both bounds
        if (integ_sum > imax_ext)
            mid_integ_next = integral_max_reg;
        else if (integ_sum < imin_ext)
            mid_integ_next = integral_min_reg;
        else
            mid_integ_next = integ_sum[mcpid_pkg::INTEG_W-1:0];
        mid_deriv_next = mcpid_pkg::DIFF_W'(mid_err_next)
                       - mcpid_pkg::DIFF_W'(prev_err_reg[in_word_reg.channel]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mcpid_pkg::CHANNELS; k++)
            begin
                error_sum_reg[k] <= '0;
                prev_err_reg[k]  <= '0;
            end
        end
        else if (upd)
        begin
            error_sum_reg[in_word_reg.channel] <= mid_integ_next;
            prev_err_reg[in_word_reg.channel]  <= mid_err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (en1)
            mid_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid_reg)
        begin
            mid_live_reg  <= live0;
            mid_chan_reg  <= in_word_reg.channel;
            mid_err_reg   <= mid_err_next;
            mid_integ_reg <= mid_integ_next;
            mid_deriv_reg <= mid_deriv_next;
        end
    end

    // ---------------- stage 2: weighted sum and saturation ----------------
    logic signed [mcpid_pkg::P_W-1:0]   prod_p;
    logic signed [mcpid_pkg::I_W-1:0]   prod_i;
    logic signed [mcpid_pkg::D_W-1:0]   prod_d;
    logic signed [mcpid_pkg::ACC_W-1:0] acc;
    logic signed [mcpid_pkg::Y_W-1:0]   y;

    always_comb
    begin
        prod_p = mcpid_pkg::P_W'($signed({1'b0, gain_p_reg}))
               * mcpid_pkg::P_W'(mid_err_reg);
        prod_i = mcpid_pkg::I_W'($signed({1'b0, gain_i_reg}))
               * mcpid_pkg::I_W'(mid_integ_reg);
        prod_d = mcpid_pkg::D_W'($signed({1'b0, gain_d_reg}))
               * mcpid_pkg::D_W'(mid_deriv_reg);
        acc    = mcpid_pkg::ACC_W'(prod_p) + mcpid_pkg::ACC_W'(prod_i)
               + mcpid_pkg::ACC_W'(prod_d);
        y      = acc[mcpid_pkg::ACC_W-1:mcpid_pkg::GAIN_FRACTION_BITS];  // floor shift

        out_word_next.channel_out = mid_chan_reg;
        out_word_next.saturated   = 1'b0;
        if (!mid_live_reg)
            out_word_next.drive = '0;
        else if (y > mcpid_pkg::Y_W'(out_max_reg))
        begin
            out_word_next.drive     = out_max_reg;
            out_word_next.saturated = 1'b1;
        end
        else if (y < mcpid_pkg::Y_W'(out_min_reg))
        begin
            out_word_next.drive     = out_min_reg;
            out_word_next.saturated = 1'b1;
        end
        else
            out_word_next.drive = y[mcpid_pkg::LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en2)
            out_valid_reg <= mid_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && mid_valid_reg)
            out_word_reg <= out_word_next;
    end

    // ---------------- assertions ----------------
    a_ready_only_blocked_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && mid_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low while the pipeline has room");

    a_integral_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && (integral_min_reg <= integral_max_reg)) |=>
        ((mid_integ_reg <= $past(integral_max_reg))
         && (mid_integ_reg >= $past(integral_min_reg))))
        else $error("stored integral outside its clamp");

    a_sat_hits_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (en2 && mid_valid_reg && out_word_next.saturated) |=>
        ((out_word_reg.drive == $past(out_max_reg))
         || (out_word_reg.drive == $past(out_min_reg))))
        else $error("saturated flag set but drive is not a limit");

endmodule
